[design/tpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged packet deframer package
// Shared types and constants for the deframer: framing phases, byte roles,
// configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package tpd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 32;
   localparam int unsigned ROLE_W      = 3;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam int unsigned SIZE_IDX_W  = 2;

   localparam logic [BYTE_W-1:0]     NAME_TERMINATOR    = 8'h00;
   localparam logic [SIZE_IDX_W-1:0] LAST_SIZE_IDX      = 2'd3;
   localparam logic [BYTE_W-1:0]     PREAMBLE_RESET     = 8'h00;
   localparam logic [BYTE_W-1:0]     TYPE_LIMIT_RESET   = 8'h04;

   typedef enum logic [2:0] {
      PH_PREAMBLE = 3'd0,
      PH_TYPE     = 3'd1,
      PH_NAME     = 3'd2,
      PH_SIZE     = 3'd3,
      PH_CONTENT  = 3'd4
   } phase_type;

   typedef enum logic [ROLE_W-1:0] {
      ROLE_SKIP     = 3'd0,
      ROLE_PREAMBLE = 3'd1,
      ROLE_TYPE     = 3'd2,
      ROLE_NAME     = 3'd3,
      ROLE_SIZE     = 3'd4,
      ROLE_CONTENT  = 3'd5
   } role_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PREAMBLE   = 1'b0,
      CSR_TYPE_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      role_type          byte_role;
      logic              name_end;
      logic [BYTE_W-1:0] packet_type;
      logic [LEN_W-1:0]  content_length;
      logic              packet_done;
      logic              type_error;
   } result_type;

endpackage

[design/tpd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged packet deframer channels
// Valid/ready channels for received bytes and for per-byte framing results.
// ----------------------------------------------------------------------------
interface tpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  byte_value;
   logic [2:0]  byte_role;
   logic        name_end;
   logic [7:0]  packet_type;
   logic [31:0] content_length;
   logic        packet_done;
   logic        type_error;

   modport source (output valid, output byte_value, output byte_role, output name_end,
                   output packet_type, output content_length, output packet_done,
                   output type_error, input ready);
   modport sink   (input valid, input byte_value, input byte_role, input name_end,
                   input packet_type, input content_length, input packet_done,
                   input type_error, output ready);
endinterface

[design/tagged_packet_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged packet deframer
// Classifies a received byte stream into preamble, type, name, size and
// content bytes, decoding the little-endian content size per packet.
// ----------------------------------------------------------------------------
// Each accepted byte is held in the input register and its result in the result register.
// Throughput: one byte per cycle while the result channel does not stall.
// An input register and a result register decouple the two channels.
// Reset (synchronous) clears the framing state to waiting for a preamble and
// loads the preamble value 0 and the type limit 4.
module tagged_packet_deframer
   import tpd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   tpd_req_if.sink                req_chan,
   tpd_rsp_if.source              rsp_chan
);

   logic [BYTE_W-1:0] preamble_ff;
   logic [BYTE_W-1:0] type_limit_ff;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   result_type        out_result_ff;
   result_type        result_in;

   logic out_free;
   logic step;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff   <= PREAMBLE_RESET;
         type_limit_ff <= TYPE_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PREAMBLE:   preamble_ff   <= csr_write_data;
            CSR_TYPE_LIMIT: type_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   tpd_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .rx_byte        (in_byte_ff),
      .preamble_value (preamble_ff),
      .type_limit     (type_limit_ff),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.byte_value     = out_result_ff.byte_value;
   assign rsp_chan.byte_role      = out_result_ff.byte_role;
   assign rsp_chan.name_end       = out_result_ff.name_end;
   assign rsp_chan.packet_type    = out_result_ff.packet_type;
   assign rsp_chan.content_length = out_result_ff.content_length;
   assign rsp_chan.packet_done    = out_result_ff.packet_done;
   assign rsp_chan.type_error     = out_result_ff.type_error;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.packet_done)
      |-> (out_result_ff.byte_role == ROLE_SIZE || out_result_ff.byte_role == ROLE_CONTENT))
      else $error("packet completed on a byte that is neither size nor content");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.name_end)
      |-> (out_result_ff.byte_role == ROLE_NAME && out_result_ff.byte_value == NAME_TERMINATOR))
      else $error("name end flagged on a byte that is not a name terminator");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_result_ff.type_error) |-> (out_result_ff.byte_role == ROLE_TYPE))
      else $error("type error flagged on a byte that is not a type byte");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> (out_valid_ff && $stable(out_result_ff)))
      else $error("stalled result lost or changed");

endmodule

[design/tpd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged packet deframer framing state machine
// Holds the framing state and classifies one byte per step.
// ----------------------------------------------------------------------------
module tpd_parser
   import tpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [BYTE_W-1:0] preamble_value,
   input  logic [BYTE_W-1:0] type_limit,
   output result_type        result
);

   phase_type               phase_ff,        phase_in;
   logic [LEN_W-1:0]        bytes_left_ff,   bytes_left_in;
   logic [SIZE_IDX_W-1:0]   size_idx_ff,     size_idx_in;
   logic [BYTE_W-1:0]       current_type_ff, current_type_in;
   logic [LEN_W-1:0]        content_size_ff, content_size_in;

   logic [LEN_W-1:0] size_gathered;
   logic [LEN_W-1:0] left_dec;

   assign size_gathered = bytes_left_ff
                          | ({{(LEN_W-BYTE_W){1'b0}}, rx_byte} << {size_idx_ff, 3'b000});
   assign left_dec      = bytes_left_ff - {{(LEN_W-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in        = phase_ff;
      bytes_left_in   = bytes_left_ff;
      size_idx_in     = size_idx_ff;
      current_type_in = current_type_ff;
      content_size_in = content_size_ff;
      unique case (phase_ff)
         PH_TYPE: begin
            if (rx_byte < type_limit) begin
               current_type_in = rx_byte;
               phase_in        = PH_NAME;
            end else begin
               phase_in = PH_PREAMBLE;
            end
         end
         PH_NAME: begin
            if (rx_byte == NAME_TERMINATOR) begin
               phase_in      = PH_SIZE;
               bytes_left_in = '0;
               size_idx_in   = '0;
            end
         end
         PH_SIZE: begin
            bytes_left_in = size_gathered;
            if (size_idx_ff == LAST_SIZE_IDX) begin
               content_size_in = size_gathered;
               size_idx_in     = '0;
               phase_in        = (size_gathered == '0) ? PH_PREAMBLE : PH_CONTENT;
            end else begin
               size_idx_in = size_idx_ff + 1'b1;
            end
         end
         PH_CONTENT: begin
            bytes_left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_PREAMBLE;
            end
         end
         default: begin
            phase_in = (rx_byte == preamble_value) ? PH_TYPE : PH_PREAMBLE;
         end
      endcase
   end

   always_comb begin
      result                = '0;
      result.byte_value     = rx_byte;
      result.byte_role      = ROLE_SKIP;
      result.packet_type    = current_type_in;
      unique case (phase_ff)
         PH_TYPE: begin
            result.byte_role  = ROLE_TYPE;
            result.type_error = (rx_byte >= type_limit);
         end
         PH_NAME: begin
            result.byte_role = ROLE_NAME;
            result.name_end  = (rx_byte == NAME_TERMINATOR);
         end
         PH_SIZE: begin
            result.byte_role = ROLE_SIZE;
            if (size_idx_ff == LAST_SIZE_IDX) begin
               result.content_length = size_gathered;
               result.packet_done    = (size_gathered == '0);
            end
         end
         PH_CONTENT: begin
            result.byte_role      = ROLE_CONTENT;
            result.content_length = content_size_ff;
            result.packet_done    = (left_dec == '0);
         end
         default: begin
            if (rx_byte == preamble_value) begin
               result.byte_role = ROLE_PREAMBLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_PREAMBLE;
         bytes_left_ff   <= '0;
         size_idx_ff     <= '0;
         current_type_ff <= '0;
         content_size_ff <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         bytes_left_ff   <= bytes_left_in;
         size_idx_ff     <= size_idx_in;
         current_type_ff <= current_type_in;
         content_size_ff <= content_size_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SIZE) |-> (bytes_left_ff >> {size_idx_ff, 3'b000}) == '0)
      else $error("size bytes gathered beyond the current size position");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CONTENT) |-> (bytes_left_ff != '0 && bytes_left_ff <= content_size_ff))
      else $error("content count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_NAME && rx_byte == NAME_TERMINATOR)
      |=> (phase_ff == PH_SIZE && size_idx_ff == '0 && bytes_left_ff == '0))
      else $error("size phase not entered cleanly after the name");

endmodule

[verif/tagged_packet_deframer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged packet deframer testbench
// Streams framed packets, broken packets and line noise into the deframer,
// with random gaps on the byte channel and random stalls on the result
// channel. A scoreboard predicts the role, type, size and completion mark of
// every byte and checks each result field against the oldest prediction.
// Several preamble and type-limit settings are used, the extremes among them.
// ----------------------------------------------------------------------------
module tagged_packet_deframer_tb;
   import tpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned ITEMS_PER_SET = 200;

   class deframe_scoreboard;
      logic [7:0]  preamble;
      logic [7:0]  type_limit;
      phase_type   phase;
      logic [31:0] size_accum;
      logic [1:0]  size_idx;
      logic [7:0]  active_type;
      logic [31:0] content_size;
      result_type  expected_q[$];
      int          error_count;

      function new();
         preamble     = PREAMBLE_RESET;
         type_limit   = TYPE_LIMIT_RESET;
         phase        = PH_PREAMBLE;
         size_accum   = '0;
         size_idx     = '0;
         active_type  = '0;
         content_size = '0;
         error_count  = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [7:0] data);
         if (idx == CSR_PREAMBLE) begin
            preamble = data;
         end else begin
            type_limit = data;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_byte(logic [7:0] b);
         result_type r;
         r = '0;
         r.byte_value = b;
         r.byte_role = ROLE_SKIP;
         case (phase)
            PH_TYPE: begin
               r.byte_role = ROLE_TYPE;
               if (b < type_limit) begin
                  active_type = b;
                  phase = PH_NAME;
               end else begin
                  r.type_error = 1'b1;
                  phase = PH_PREAMBLE;
               end
            end
            PH_NAME: begin
               r.byte_role = ROLE_NAME;
               if (b == NAME_TERMINATOR) begin
                  r.name_end = 1'b1;
                  phase = PH_SIZE;
                  size_accum = '0;
                  size_idx = '0;
               end
            end
            PH_SIZE: begin
               r.byte_role = ROLE_SIZE;
               size_accum = size_accum | (32'(b) << (8 * size_idx));
               if (size_idx == LAST_SIZE_IDX) begin
                  content_size = size_accum;
                  r.content_length = content_size;
                  size_idx = '0;
                  if (content_size == 0) begin
                     r.packet_done = 1'b1;
                     phase = PH_PREAMBLE;
                  end else begin
                     phase = PH_CONTENT;
                  end
               end else begin
                  size_idx = size_idx + 2'd1;
               end
            end
            PH_CONTENT: begin
               r.byte_role = ROLE_CONTENT;
               r.content_length = content_size;
               size_accum = size_accum - 32'd1;
               if (size_accum == 0) begin
                  r.packet_done = 1'b1;
                  phase = PH_PREAMBLE;
               end
            end
            default: begin
               phase = PH_PREAMBLE;
               if (b == preamble) begin
                  r.byte_role = ROLE_PREAMBLE;
                  phase = PH_TYPE;
               end
            end
         endcase
         r.packet_type = active_type;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
         if (got_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
            error_count++;
         end
      endfunction

      function void check_result(result_type got);
         result_type exp_r;
         if (expected_q.size() == 0) begin
            $error("Result with no transaction pending: byte_value %0h", got.byte_value);
            error_count++;
            return;
         end
         exp_r = expected_q.pop_front();
         compare_field("byte_value", exp_r.byte_value, got.byte_value);
         compare_field("byte_role", exp_r.byte_role, got.byte_role);
         compare_field("name_end", exp_r.name_end, got.name_end);
         compare_field("packet_type", exp_r.packet_type, got.packet_type);
         compare_field("content_length", exp_r.content_length, got.content_length);
         compare_field("packet_done", exp_r.packet_done, got.packet_done);
         compare_field("type_error", exp_r.type_error, got.type_error);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   tpd_req_if req ();
   tpd_rsp_if rsp ();

   deframe_scoreboard board = new();

   bit          req_burst;
   bit          rsp_burst;
   int unsigned bytes_sent;
   int unsigned cycle_count;

   tagged_packet_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req),
      .rsp_chan         (rsp)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) begin
         req_burst = !req_burst;
      end
      gap = req_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.rx_byte <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_packet();
      int unsigned kind;
      int unsigned length;
      logic [7:0]  b;
      logic [7:0]  ptype;
      logic [31:0] size;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         length = $urandom_range(1, 5);
         repeat (length) begin
            b = 8'($urandom);
            if (b == board.preamble) begin
               b = ~b;
            end
            send_byte(b);
         end
      end else if (kind == 2) begin
         send_byte(board.preamble);
         send_byte(8'($urandom_range(board.type_limit, 255)));
      end else begin
         send_byte(board.preamble);
         if (board.type_limit == 0) begin
            ptype = 8'($urandom);
         end else begin
            ptype = 8'($urandom_range(0, board.type_limit - 1));
         end
         send_byte(ptype);
         if (ptype >= board.type_limit) begin
            return;
         end
         length = $urandom_range(0, 6);
         repeat (length) send_byte(8'($urandom_range(1, 255)));
         send_byte(NAME_TERMINATOR);
         if ($urandom_range(0, 24) == 0) begin
            size = $urandom_range(13, 300);
         end else begin
            size = $urandom_range(0, 12);
         end
         for (int i = 0; i < 4; i++) begin
            send_byte(size[8*i +: 8]);
         end
         repeat (size) send_byte(8'($urandom));
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic set_registers(input logic [7:0] preamble, input logic [7:0] limit);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_PREAMBLE;
      csr_write_data <= preamble;
      @(posedge clock);
      csr_index <= CSR_TYPE_LIMIT;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.write_reg(CSR_PREAMBLE, preamble);
      board.write_reg(CSR_TYPE_LIMIT, limit);
   endtask

   initial begin
      result_type got;
      rsp.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         int unsigned stall;
         if ($urandom_range(0, 39) == 0) begin
            rsp_burst = !rsp_burst;
         end
         stall = rsp_burst ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         got.byte_value     = rsp.byte_value;
         got.byte_role      = role_type'(rsp.byte_role);
         got.name_end       = rsp.name_end;
         got.packet_type    = rsp.packet_type;
         got.content_length = rsp.content_length;
         got.packet_done    = rsp.packet_done;
         got.type_error     = rsp.type_error;
         board.check_result(got);
      end
   end

   initial begin
      logic [7:0]  directed_bytes[23];
      logic [7:0]  preamble_set[5];
      logic [7:0]  limit_set[5];
      int unsigned start_count;
      directed_bytes = '{
         8'hFF, 8'h55,
         8'h00, 8'h03, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
         8'h00, 8'h04,
         8'h00, 8'hFF,
         8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA
      };
      preamble_set = '{8'hFF, 8'hA5, 8'h00, 8'h3C, 8'h00};
      limit_set    = '{8'hFF, 8'h01, 8'h00, 8'h04, 8'h00};
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_PREAMBLE;
      csr_write_data   <= '0;
      req.valid        <= 1'b0;
      req.rx_byte      <= '0;
      cycle_count      <= 0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      bytes_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_bytes[i]) begin
         send_byte(directed_bytes[i]);
      end

      for (int s = 0; s < 5; s++) begin
         if (s == 4) begin
            preamble_set[s] = 8'($urandom);
            limit_set[s] = 8'($urandom);
         end
         drain();
         set_registers(preamble_set[s], limit_set[s]);
         start_count = bytes_sent;
         while (bytes_sent - start_count < ITEMS_PER_SET) begin
            send_packet();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
